// File: hdl/ec_pkg.sv
package ec_pkg;

    // widths of the fields and of the internal day/second values
    localparam int EC_IN_W    = 64;
    localparam int EC_DAYS_W  = 22;
    localparam int EC_SOD_W   = 17;
    localparam int EC_SEC_W   = 6;
    localparam int EC_MIN_W   = 6;
    localparam int EC_HOUR_W  = 5;
    localparam int EC_MDAY_W  = 5;
    localparam int EC_MON_W   = 4;
    localparam int EC_YEAR_W  = 14;
    localparam int EC_WDAY_W  = 3;
    localparam int EC_OUT_W   = 48;

    // pipeline depths of the two sections
    localparam int EC_DS_STAGES  = 3;
    localparam int EC_CIV_STAGES = 8;

    // calendar constants
    localparam longint unsigned EC_SECS_PER_DAY = 86400;
    localparam longint unsigned EC_MAX_DAYS     = 2932896;
    localparam longint unsigned EC_LAST_SEC     = 86399;
    localparam longint unsigned EC_MAR1BC_OFS   = 719527;
    localparam longint unsigned EC_DAYS_400Y    = 365 * 400 + 100 - 4 + 1;
    localparam longint unsigned EC_EPOCH_OFS    = EC_MAR1BC_OFS - (31 + 28);

    // first second that lies beyond 9999-12-31 23:59:59
    localparam logic [37:0] EC_SAT_SECS = 38'((EC_MAX_DAYS + 1) * EC_SECS_PER_DAY);

    // seconds per day = 128 * 675: shift by seven, then divide by 675
    localparam int          EC_DAY_LSB = 7;
    localparam longint unsigned EC_DAY_DIV = EC_SECS_PER_DAY / (64'd1 << EC_DAY_LSB);
    localparam int          EC_DAY_SH  = 31;
    localparam logic [21:0] EC_DAY_RCP = 22'((64'd1 << EC_DAY_SH) / EC_DAY_DIV);

    // floor reciprocals, each followed by one correction step
    localparam int          EC_HOUR_SH  = 17;
    localparam logic [5:0]  EC_HOUR_RCP = 6'((64'd1 << EC_HOUR_SH) / 3600);
    localparam int          EC_MIN_SH   = 12;
    localparam logic [6:0]  EC_MIN_RCP  = 7'((64'd1 << EC_MIN_SH) / 60);
    localparam int          EC_WDAY_SH  = 22;
    localparam logic [19:0] EC_WDAY_RCP = 20'((64'd1 << EC_WDAY_SH) / 7);
    localparam int          EC_YEAR_SH  = 31;
    localparam logic [13:0] EC_YEAR_RCP = 14'((64'd1 << EC_YEAR_SH) / EC_DAYS_400Y);

    // exact for the ranges used: x / 25 for x below 4096
    localparam logic [12:0] EC_DIV25_RCP = 13'd5243;
    localparam int          EC_DIV25_SH  = 17;

    // exact for the ranges used: x * 10 / 306 for x below 1200
    localparam logic [15:0] EC_MON_RCP = 16'd34270;
    localparam int          EC_MON_SH  = 20;

    // first day of a march-based month, floor(367 * m / 12) - 30
    function automatic logic [8:0] ec_month_start(input logic [EC_MON_W-1:0] mon);
        logic [8:0] v;
        unique case (mon)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd61;
            4'd4:    v = 9'd92;
            4'd5:    v = 9'd122;
            4'd6:    v = 9'd153;
            4'd7:    v = 9'd184;
            4'd8:    v = 9'd214;
            4'd9:    v = 9'd245;
            4'd10:   v = 9'd275;
            4'd11:   v = 9'd306;
            4'd12:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/epoch_seconds_to_calendar.sv
// Converts a signed count of seconds since 1970-01-01 00:00:00 UTC into the UTC
// calendar date and time. One item in gives one item out, in order. The block is
// a fully pipelined chain of 11 register stages: 3 that split the seconds into
// whole days and second of day (a floor-reciprocal multiply by 1/675 after a
// shift by seven, then one correction), and 8 that run the Gauss day count on a
// March-based year in parallel with the hour/minute/second and weekday split.
// It takes one item every cycle while the output is not stalled; each stage holds
// only while its successor is full and cannot pass its item on, so a stall on the
// output only backs up as far as needed and empty stages keep taking items.
// Negative inputs give 1970-01-01 00:00:00 (Thursday); anything past
// 9999-12-31 23:59:59 gives exactly that moment. No state is kept between items.
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] unix_seconds (signed)
    // result item stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [5:0] second, [11:6] minute, [16:12] hour,
                                        // [21:17] day_of_month, [25:22] month,
                                        // [39:26] year, [42:40] weekday, [47:43] zero
);
    import ec_pkg::*;

    // day split to calendar section
    logic                 w_ds_valid;
    logic                 w_ds_ready;
    logic [EC_DAYS_W-1:0] w_days;
    logic [EC_SOD_W-1:0]  w_sod;

    // finished fields
    logic [EC_SEC_W-1:0]  w_second;
    logic [EC_MIN_W-1:0]  w_minute;
    logic [EC_HOUR_W-1:0] w_hour;
    logic [EC_MDAY_W-1:0] w_mday;
    logic [EC_MON_W-1:0]  w_month;
    logic [EC_YEAR_W-1:0] w_year;
    logic [EC_WDAY_W-1:0] w_wday;

    // clamp, saturate, whole days and second of day
    ec_day_split u_day_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_seconds (s_axis_tdata),
        .o_valid   (w_ds_valid),
        .i_ready   (w_ds_ready),
        .o_days    (w_days),
        .o_sod     (w_sod)
    );

    // gauss date, time of day and weekday; last stage is the output register
    ec_civil u_civil (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_ds_valid),
        .o_ready  (w_ds_ready),
        .i_days   (w_days),
        .i_sod    (w_sod),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_second (w_second),
        .o_minute (w_minute),
        .o_hour   (w_hour),
        .o_mday   (w_mday),
        .o_month  (w_month),
        .o_year   (w_year),
        .o_wday   (w_wday)
    );

    // pack fields, first field in the lowest bits
    assign m_axis_tdata = {5'b0, w_wday, w_year, w_month, w_mday, w_hour, w_minute, w_second};

endmodule

// File: hdl/ec_pipe_ctl.sv
module ec_pipe_ctl #(
    parameter int Depth = ec_pkg::EC_CIV_STAGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [Depth-1:0] o_load
);
    import ec_pkg::*;

    logic [Depth-1:0] r_vld;
    logic [Depth-1:0] n_vld;
    logic [Depth-1:0] w_rdy;
    logic [Depth-1:0] w_prev;

    // a stage takes new data when it is empty or its successor is ready to take its item
    always_comb begin
        w_rdy[Depth-1] = !r_vld[Depth-1] || i_ready;
        for (int k = Depth - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        w_prev[0] = i_valid;
        for (int k = 1; k < Depth; k++) begin
            w_prev[k] = r_vld[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < Depth; k++) begin
            o_load[k] = w_rdy[k] && w_prev[k];
            n_vld[k]  = w_rdy[k] ? w_prev[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[Depth-1];

    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("finished item dropped while stalled");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> o_ready)
        else $error("empty first stage refuses an item");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted item not held in first stage");

endmodule

// File: hdl/ec_day_split.sv
module ec_day_split (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ec_pkg::EC_IN_W-1:0]    i_seconds,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ec_pkg::EC_DAYS_W-1:0]  o_days,
    output logic [ec_pkg::EC_SOD_W-1:0]   o_sod
);
    import ec_pkg::*;

    logic [EC_DS_STAGES-1:0] w_load;

    // stage a: clamp and range check
    logic [30:0] r_a_x, n_a_x;
    logic [6:0]  r_a_lo, n_a_lo;
    logic        r_a_sat, n_a_sat;
    // stage b: reciprocal product
    logic [21:0] r_b_q0, n_b_q0;
    logic [30:0] r_b_x;
    logic [6:0]  r_b_lo;
    logic        r_b_sat;
    // stage c: correction, saturation
    logic [EC_DAYS_W-1:0] r_c_days, n_c_days;
    logic [EC_SOD_W-1:0]  r_c_sod, n_c_sod;

    logic        w_neg;
    logic        w_big;
    logic [52:0] w_prod;
    logic [30:0] w_rem;
    logic [10:0] w_r;

    ec_pipe_ctl #(
        .Depth (EC_DS_STAGES)
    ) u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_load  (w_load)
    );

    always_comb begin
        w_neg   = i_seconds[EC_IN_W-1];
        w_big   = (|i_seconds[EC_IN_W-2:38]) || (i_seconds[37:0] >= EC_SAT_SECS);
        n_a_sat = !w_neg && w_big;
        n_a_x   = w_neg ? '0 : i_seconds[37:EC_DAY_LSB];
        n_a_lo  = w_neg ? '0 : i_seconds[EC_DAY_LSB-1:0];
    end

    always_comb begin
        w_prod = 53'(r_a_x) * 53'(EC_DAY_RCP);
        n_b_q0 = w_prod[52:EC_DAY_SH];
    end

    // quotient is exact or one short
    always_comb begin
        w_rem = r_b_x - 31'(31'(r_b_q0) * 31'(EC_DAY_DIV));
        w_r   = w_rem[10:0];
        if (w_r >= 11'(EC_DAY_DIV)) begin
            n_c_days = r_b_q0 + 22'd1;
            w_r      = w_r - 11'(EC_DAY_DIV);
        end else begin
            n_c_days = r_b_q0;
        end
        n_c_sod = {w_r[9:0], r_b_lo};
        if (r_b_sat) begin
            n_c_days = EC_DAYS_W'(EC_MAX_DAYS);
            n_c_sod  = EC_SOD_W'(EC_LAST_SEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_a_x   <= n_a_x;
            r_a_lo  <= n_a_lo;
            r_a_sat <= n_a_sat;
        end
        if (w_load[1]) begin
            r_b_q0  <= n_b_q0;
            r_b_x   <= r_a_x;
            r_b_lo  <= r_a_lo;
            r_b_sat <= r_a_sat;
        end
        if (w_load[2]) begin
            r_c_days <= n_c_days;
            r_c_sod  <= n_c_sod;
        end
    end

    assign o_days = r_c_days;
    assign o_sod  = r_c_sod;

endmodule

// File: hdl/ec_civil.sv
module ec_civil (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ec_pkg::EC_DAYS_W-1:0]  i_days,
    input  logic [ec_pkg::EC_SOD_W-1:0]   i_sod,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ec_pkg::EC_SEC_W-1:0]   o_second,
    output logic [ec_pkg::EC_MIN_W-1:0]   o_minute,
    output logic [ec_pkg::EC_HOUR_W-1:0]  o_hour,
    output logic [ec_pkg::EC_MDAY_W-1:0]  o_mday,
    output logic [ec_pkg::EC_MON_W-1:0]   o_month,
    output logic [ec_pkg::EC_YEAR_W-1:0]  o_year,
    output logic [ec_pkg::EC_WDAY_W-1:0]  o_wday
);
    import ec_pkg::*;

    typedef struct packed {
        logic [21:0]          d;
        logic [30:0]          n;
        logic [21:0]          w;
        logic [18:0]          wq;
        logic [EC_WDAY_W-1:0] wday;
        logic [EC_SOD_W-1:0]  sod;
        logic [EC_HOUR_W-1:0] hour;
        logic [11:0]          rem;
        logic [5:0]           mq;
        logic [EC_MIN_W-1:0]  minute;
        logic [EC_SEC_W-1:0]  second;
        logic [EC_YEAR_W-1:0] year;
        logic [11:0]          y4;
        logic [6:0]           y100;
        logic [4:0]           y400;
        logic [21:0]          base;
        logic                 leap;
        logic [8:0]           yday;
        logic [EC_MON_W-1:0]  mon;
        logic [EC_MDAY_W-1:0] mday;
    } t_ec_civ;

    logic [EC_CIV_STAGES-1:0] w_load;
    t_ec_civ r_st [EC_CIV_STAGES];
    t_ec_civ n_st [EC_CIV_STAGES];

    logic [22:0] w_hp;
    logic [41:0] w_wp;
    logic [44:0] w_yp;
    logic [30:0] w_ry;
    logic [16:0] w_hr;
    logic [21:0] w_wr;
    logic [18:0] w_mp;
    logic [11:0] w_mr;
    logic [24:0] w_p100;
    logic [22:0] w_p400;
    logic [22:0] w_diff;
    logic [24:0] w_monp;
    logic [8:0]  w_mday;

    ec_pipe_ctl #(
        .Depth (EC_CIV_STAGES)
    ) u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_load  (w_load)
    );

    // stage 0: day offsets, gauss numerator, hour estimate
    always_comb begin
        n_st[0]      = '0;
        n_st[0].d    = i_days + 22'(EC_EPOCH_OFS);
        n_st[0].n    = 31'((31'(n_st[0].d) + 31'd2) * 31'd400);
        n_st[0].w    = i_days + 22'd4;
        n_st[0].sod  = i_sod;
        w_hp         = 23'(i_sod) * 23'(EC_HOUR_RCP);
        n_st[0].hour = w_hp[21:EC_HOUR_SH];
    end

    // stage 1: year and weekday estimates, hour correction
    always_comb begin
        n_st[1]      = r_st[0];
        w_yp         = 45'(r_st[0].n) * 45'(EC_YEAR_RCP);
        n_st[1].year = w_yp[44:EC_YEAR_SH];
        w_wp         = 42'(r_st[0].w) * 42'(EC_WDAY_RCP);
        n_st[1].wq   = w_wp[40:EC_WDAY_SH];
        w_hr         = r_st[0].sod - 17'(17'(r_st[0].hour) * 17'd3600);
        if (w_hr >= 17'd3600) begin
            n_st[1].hour = r_st[0].hour + 5'd1;
            w_hr         = w_hr - 17'd3600;
        end
        n_st[1].rem  = w_hr[11:0];
    end

    // stage 2: year and weekday corrections, minute estimate
    always_comb begin
        n_st[2] = r_st[1];
        w_ry    = r_st[1].n - 31'(31'(r_st[1].year) * 31'(EC_DAYS_400Y));
        if (w_ry >= 31'(EC_DAYS_400Y)) begin
            n_st[2].year = r_st[1].year + 14'd1;
        end
        w_wr = r_st[1].w - 22'(22'(r_st[1].wq) * 22'd7);
        if (w_wr >= 22'd7) begin
            w_wr = w_wr - 22'd7;
        end
        n_st[2].wday = w_wr[2:0];
        w_mp         = 19'(r_st[1].rem) * 19'(EC_MIN_RCP);
        n_st[2].mq   = w_mp[17:EC_MIN_SH];
    end

    // stage 3: century terms, minute correction
    always_comb begin
        n_st[3]      = r_st[2];
        n_st[3].y4   = r_st[2].year[13:2];
        w_p100       = 25'(r_st[2].year[13:2]) * 25'(EC_DIV25_RCP);
        n_st[3].y100 = w_p100[23:EC_DIV25_SH];
        w_p400       = 23'(r_st[2].year[13:4]) * 23'(EC_DIV25_RCP);
        n_st[3].y400 = w_p400[21:EC_DIV25_SH];
        w_mr         = r_st[2].rem - 12'(12'(r_st[2].mq) * 12'd60);
        n_st[3].minute = r_st[2].mq;
        if (w_mr >= 12'd60) begin
            n_st[3].minute = r_st[2].mq + 6'd1;
            w_mr           = w_mr - 12'd60;
        end
        n_st[3].second = w_mr[5:0];
    end

    // stage 4: days before the march-based year, leap flag
    always_comb begin
        n_st[4]      = r_st[3];
        n_st[4].base = 22'(r_st[3].year) * 22'd365 + 22'(r_st[3].y4)
                     - 22'(r_st[3].y100) + 22'(r_st[3].y400);
        n_st[4].leap = (r_st[3].year[1:0] == 2'b00)
                     && ((14'(14'(r_st[3].y100) * 14'd100) != r_st[3].year)
                     || (14'(14'(r_st[3].y400) * 14'd400) == r_st[3].year));
    end

    // stage 5: day of year, step back a year when it comes out negative
    always_comb begin
        n_st[5] = r_st[4];
        w_diff  = {1'b0, r_st[4].d} - {1'b0, r_st[4].base};
        if (w_diff[22]) begin
            n_st[5].yday = 9'(w_diff + 23'd365 + 23'(r_st[4].leap));
            n_st[5].year = r_st[4].year - 14'd1;
        end else begin
            n_st[5].yday = w_diff[8:0];
        end
    end

    // stage 6: march-based month
    always_comb begin
        n_st[6]     = r_st[5];
        w_monp      = 25'(r_st[5].yday + 9'd31) * 25'(EC_MON_RCP);
        n_st[6].mon = w_monp[23:EC_MON_SH];
    end

    // stage 7: day of month, back to a january-based year
    always_comb begin
        n_st[7]      = r_st[6];
        w_mday       = r_st[6].yday - ec_month_start(r_st[6].mon) + 9'd1;
        n_st[7].mday = w_mday[4:0];
        if (r_st[6].yday >= 9'd306) begin
            n_st[7].year = r_st[6].year + 14'd1;
            n_st[7].mon  = r_st[6].mon - 4'd10;
        end else begin
            n_st[7].mon  = r_st[6].mon + 4'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < EC_CIV_STAGES; k++) begin
            if (w_load[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_second = r_st[EC_CIV_STAGES-1].second;
    assign o_minute = r_st[EC_CIV_STAGES-1].minute;
    assign o_hour   = r_st[EC_CIV_STAGES-1].hour;
    assign o_mday   = r_st[EC_CIV_STAGES-1].mday;
    assign o_month  = r_st[EC_CIV_STAGES-1].mon;
    assign o_year   = r_st[EC_CIV_STAGES-1].year;
    assign o_wday   = r_st[EC_CIV_STAGES-1].wday;

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1) && (o_month <= 4'd12))
        else $error("month out of range");

    a_mday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mday >= 5'd1) && (o_mday <= 5'd31))
        else $error("day of month out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour <= 5'd23) && (o_minute <= 6'd59) && (o_second <= 6'd59)
                    && (o_wday <= 3'd6))
        else $error("time of day or weekday out of range");

endmodule

// File: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ec_pkg::*;

    // cycles with no item moving on either side before the run is called hung
    localparam int QUIET_LIMIT = 2000;
    localparam int PIPE_DEPTH  = EC_DS_STAGES + EC_CIV_STAGES;

    typedef struct {
        logic [EC_SEC_W-1:0]  second;
        logic [EC_MIN_W-1:0]  minute;
        logic [EC_HOUR_W-1:0] hour;
        logic [EC_MDAY_W-1:0] day_of_month;
        logic [EC_MON_W-1:0]  month;
        logic [EC_YEAR_W-1:0] year;
        logic [EC_WDAY_W-1:0] weekday;
    } t_calendar;

    // receiver behavior, picked anew at random whenever the current mode runs out
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_HOLD
    } t_rx_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    wire                 s_axis_tready;
    logic [EC_IN_W-1:0]  s_axis_tdata = '0;   // [63:0] unix_seconds (signed)
    wire                 m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    wire  [EC_OUT_W-1:0] m_axis_tdata;        // [5:0] second, [11:6] minute, [16:12] hour,
                                              // [21:17] day_of_month, [25:22] month,
                                              // [39:26] year, [42:40] weekday, [47:43] zero

    t_calendar expected_dates[$];
    int        error_count = 0;
    int        quiet_cycles = 0;
    int        burst_left = 0;
    t_rx_mode  rx_mode = RX_OPEN;
    int        rx_left = 0;
    int        rx_tick = 0;

    epoch_seconds_to_calendar dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // gauss day count on a march-based year, clamped below at the epoch
    // and saturated at the last second of year 9999
    function automatic t_calendar civil_from_epoch(input logic [EC_IN_W-1:0] raw);
        longint unsigned secs, days, sod, d, yr, mon, mday, year_start;
        longint          doy;
        t_calendar       c;
        secs = raw[EC_IN_W-1] ? 64'd0 : raw;
        days = secs / EC_SECS_PER_DAY;
        sod  = secs % EC_SECS_PER_DAY;
        if (days > EC_MAX_DAYS) begin
            days = EC_MAX_DAYS;
            sod  = EC_LAST_SEC;
        end
        c.weekday = EC_WDAY_W'((4 + days) % 7);
        c.hour    = EC_HOUR_W'(sod / 3600);
        c.minute  = EC_MIN_W'((sod % 3600) / 60);
        c.second  = EC_SEC_W'(sod % 60);

        // days since 1 march of 1 bc
        d          = days + EC_EPOCH_OFS;
        yr         = (d + 2) * 400 / EC_DAYS_400Y;
        year_start = 365 * yr + yr / 4 - yr / 100 + yr / 400;
        doy        = longint'(d) - longint'(year_start);
        // late february lands before the provisional year start
        if (doy < 0) begin
            if ((yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0)))
                doy += 366;
            else
                doy += 365;
            yr--;
        end
        mon  = (unsigned'(doy) + 31) * 10 / 306;
        mday = unsigned'(doy) - (367 * mon / 12 - 30) + 1;
        if (doy >= 306) begin
            yr++;
            mon -= 10;
        end else begin
            mon += 2;
        end
        c.day_of_month = EC_MDAY_W'(mday);
        c.month        = EC_MON_W'(mon);
        c.year         = EC_YEAR_W'(yr);
        return c;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // one item; bursts of random length with random gaps between them
    task automatic send_seconds(input logic [EC_IN_W-1:0] secs);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= secs;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // hold the sender until every pending date has come back
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (expected_dates.size() != 0);
    endtask

    task automatic test_negative_clamp();
        send_seconds(64'd0);
        send_seconds('1);
        send_seconds(64'h8000_0000_0000_0000);
        send_seconds(-64'sd86400);
    endtask

    task automatic test_day_and_year_edges();
        send_seconds(64'd86399);        // last second of the first day
        send_seconds(64'd86400);
        send_seconds(64'd5097599);      // 1970 end of february
        send_seconds(64'd5097600);
        send_seconds(64'd31535999);     // new year 1971
        send_seconds(64'd31536000);
        send_seconds(64'd68169600);     // 1972 leap day
        send_seconds(64'd68256000);
        send_seconds(64'd951782400);    // 2000 leap day, 400-year rule
        send_seconds(64'd951868800);
        send_seconds(64'd4107542399);   // 2100 has no leap day
        send_seconds(64'd4107542400);
    endtask

    task automatic test_saturation();
        send_seconds(EC_MAX_DAYS * EC_SECS_PER_DAY);   // start of the last day
        send_seconds(64'(EC_SAT_SECS) - 1);
        send_seconds(64'(EC_SAT_SECS));
        send_seconds(64'h0000_0040_0000_0000);
        send_seconds(64'h7FFF_FFFF_FFFF_FFFF);
        send_seconds(64'h0000_0000_FFFF_FFFF);
    endtask

    // whole range of valid dates and the day just past it, weighted toward day boundaries
    task automatic test_random_dates();
        longint unsigned days, sod;
        for (int i = 0; i < 800; i++) begin
            days = $urandom_range(0, EC_MAX_DAYS + 1);
            case ($urandom_range(0, 3))
                0:       sod = 0;
                1:       sod = EC_LAST_SEC;
                default: sod = $urandom_range(0, EC_LAST_SEC);
            endcase
            send_seconds(days * EC_SECS_PER_DAY + sod);
            if (i == 400)
                wait_results_drained();
        end
    endtask

    // negatives, huge values and the neighborhood of the saturation point
    task automatic test_random_wide();
        logic [EC_IN_W-1:0] v;
        for (int i = 0; i < 400; i++) begin
            v = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0:       ;
                1:       v[EC_IN_W-1] = 1'b1;
                2:       v = v >> $urandom_range(1, 63);
                default: v = 64'(EC_SAT_SECS) - 100 + $urandom_range(0, 200);
            endcase
            send_seconds(v);
        end
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(5, 30) : $urandom_range(20, 150);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: m_axis_tready <= (rx_tick % 5 == 0);
            default:   m_axis_tready <= 1'b0;
        endcase
    end

    // predict each accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_dates.push_back(civil_from_epoch(s_axis_tdata));
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_calendar want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_dates.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                want = expected_dates.pop_front();
                check_field("second",       int'(want.second),       int'(m_axis_tdata[5:0]));
                check_field("minute",       int'(want.minute),       int'(m_axis_tdata[11:6]));
                check_field("hour",         int'(want.hour),         int'(m_axis_tdata[16:12]));
                check_field("day_of_month", int'(want.day_of_month), int'(m_axis_tdata[21:17]));
                check_field("month",        int'(want.month),        int'(m_axis_tdata[25:22]));
                check_field("year",         int'(want.year),         int'(m_axis_tdata[39:26]));
                check_field("weekday",      int'(want.weekday),      int'(m_axis_tdata[42:40]));
                check_field("padding",      0,                       int'(m_axis_tdata[47:43]));
            end
        end
    end

    // hang detection
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_negative_clamp();
        test_day_and_year_edges();
        test_saturation();
        test_random_dates();
        test_random_wide();

        s_axis_tvalid <= 1'b0;
        while (expected_dates.size() != 0) @(negedge i_clk);
        // catch any stray result behind the last one
        repeat (PIPE_DEPTH + 8) @(negedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
